FILE: rtl/wpcc_pkg.sv
// Shared widths, operation codes, divider request types and helpers for the chi2 unit.
package wpcc_pkg;

    // Field widths
    localparam int OP_W    = 3;
    localparam int IDX_W   = 12;
    localparam int WGT_W   = 16;
    localparam int DD_W    = 32;
    localparam int ERR_W   = 16;
    localparam int OUT_W   = 32;
    localparam int CHI_W   = 48;
    localparam int DOF_W   = 16;

    // Accumulator widths
    localparam int SUM_W   = 28;
    localparam int SQ_W    = 44;
    localparam int PAIR_W  = 44;
    localparam int E_W     = 33;

    // Shared multiplier and divider
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FRAC_SH = 24;
    localparam int TERM_SH = 8;
    localparam int NUM_W   = PAIR_W + FRAC_SH;
    localparam int DEN_W   = 2 * SUM_W - 1;
    localparam int QUO_W   = CHI_W;

    localparam int STAR_DEPTH_DEFAULT = 4096;

    localparam logic [OUT_W-1:0] ONE_Q24 = OUT_W'(1) << FRAC_SH;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_PAIR  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd2;
    localparam logic [OP_W-1:0] OP_POINT = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    // Clamp a divider quotient to 32 bits
    function automatic logic [OUT_W-1:0] sat32(input logic [QUO_W-1:0] q);
        logic [OUT_W-1:0] r;
        r = (|q[QUO_W-1:OUT_W]) ? {OUT_W{1'b1}} : q[OUT_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/wpcc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, saturating at 48 bits.
module wpcc_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  wpcc_pkg::div_req_t req,
    output wpcc_pkg::div_rsp_t rsp
);
    import wpcc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W-1:0] hi_ext;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Upper numerator bits set the overflow check and the first remainder
    assign hi_ext  = DEN_W'(req.num[NUM_W-1:QUO_W]);
    assign shifted = {rem_reg, quo_reg[QUO_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    // Step logic
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            den_next = req.den;
            if (hi_ext >= req.den)
            begin
                // quotient does not fit: clamp
                quo_next  = {QUO_W{1'b1}};
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = hi_ext;
                quo_next  = req.num[QUO_W-1:0];
                cnt_next  = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/weighted_pair_correlation_chi2_unit.sv
// Top level: weight store, accumulators and close-bin sequencer of the chi2 unit.
//
// One request is worked on at a time. A pair goes through a registered dual read of the
// weight RAM, then the shared 32x32 multiplier, then the saturating add. A close-bin
// request runs setup and handoff states, and when the normalization is nonzero one pass
// of the shared radix-2 divider for each division it needs (MM, DD/MM, |corr-1|/corr
// and the chi2 term). The result waits in an output register, and further load and
// pair requests are taken while it waits; a close-bin request holds in its last state
// until that register is free. The weight RAM has no reset and no clearing pass: a pair
// must only name entries loaded before.
module weighted_pair_correlation_chi2_unit
#(
    parameter int STAR_DEPTH = wpcc_pkg::STAR_DEPTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [wpcc_pkg::OP_W-1:0]   op,
    input  logic [wpcc_pkg::IDX_W-1:0]  first_index,
    input  logic [wpcc_pkg::IDX_W-1:0]  second_index,
    input  logic [wpcc_pkg::WGT_W-1:0]  weight_value,
    input  logic [wpcc_pkg::DD_W-1:0]   dd_value,
    input  logic [wpcc_pkg::ERR_W-1:0]  dd_frac_error,
    input  logic [wpcc_pkg::ERR_W-1:0]  mm_frac_error,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [wpcc_pkg::OUT_W-1:0]  mm_value,
    output logic [wpcc_pkg::OUT_W-1:0]  corr_value,
    output logic                        bin_counted,
    output logic [wpcc_pkg::CHI_W-1:0]  chi2_total,
    output logic [wpcc_pkg::DOF_W-1:0]  dof_count,
    output logic                        status
);
    import wpcc_pkg::*;

    localparam int AW = $clog2(STAR_DEPTH);

    // Sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_LOAD_ACC  = 4'd1;
    localparam logic [3:0] ST_PAIR_MUL  = 4'd2;
    localparam logic [3:0] ST_PAIR_ACC  = 4'd3;
    localparam logic [3:0] ST_SSQ       = 4'd4;
    localparam logic [3:0] ST_NORM      = 4'd5;
    localparam logic [3:0] ST_DESQ      = 4'd6;
    localparam logic [3:0] ST_MESQ      = 4'd7;
    localparam logic [3:0] ST_DIV_MM    = 4'd8;
    localparam logic [3:0] ST_DIV_CORR  = 4'd9;
    localparam logic [3:0] ST_RATIO_GO  = 4'd10;
    localparam logic [3:0] ST_DIV_RATIO = 4'd11;
    localparam logic [3:0] ST_RSQ       = 4'd12;
    localparam logic [3:0] ST_TERM_GO   = 4'd13;
    localparam logic [3:0] ST_DIV_TERM  = 4'd14;
    localparam logic [3:0] ST_OUT       = 4'd15;

    // Weight RAM
    logic [WGT_W-1:0] weight_mem [STAR_DEPTH];
    logic [WGT_W-1:0] rd_a_reg, rd_b_reg;
    logic             wr_en;
    logic [AW-1:0]    addr_a, addr_b;

    // Control state
    logic [3:0]        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [PAIR_W-1:0] pair_reg, pair_next;
    logic [CHI_W-1:0]  chi2_reg, chi2_next;
    logic [DOF_W-1:0]  dof_reg, dof_next;

    // Close-bin working registers
    logic [DD_W-1:0]   dd_reg, dd_next;
    logic [ERR_W-1:0]  de_reg, de_next;
    logic [ERR_W-1:0]  me_reg, me_next;
    logic [DEN_W-1:0]  norm_reg, norm_next;
    logic [E_W-1:0]    e2_reg, e2_next;
    logic [OUT_W-1:0]  mm_reg, mm_next;
    logic [OUT_W-1:0]  corr_reg, corr_next;
    logic [OUT_W-1:0]  ratio_reg, ratio_next;
    logic              status_reg, status_next;
    logic              counted_reg, counted_next;

    // Output register
    logic [OUT_W-1:0]  mm_out_reg, mm_out_next;
    logic [OUT_W-1:0]  corr_out_reg, corr_out_next;
    logic              counted_out_reg, counted_out_next;
    logic [CHI_W-1:0]  chi2_out_reg, chi2_out_next;
    logic [DOF_W-1:0]  dof_out_reg, dof_out_next;
    logic              status_out_reg, status_out_next;

    // Shared multiplier
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_reg, mul_next;

    // Divider link
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Misc combinational
    logic              accept;
    logic              out_free;
    logic              a_ok, b_ok;
    logic [SUM_W:0]    sum_add;
    logic [SQ_W:0]     sq_add;
    logic [PAIR_W:0]   pair_add;
    logic [CHI_W:0]    chi_add;
    logic [DOF_W:0]    dof_add;
    logic [2*SUM_W-1:0] s2;
    logic [2*SUM_W-1:0] s2_diff;
    logic [OUT_W-1:0]  q32;
    logic [OUT_W-1:0]  ratio_diff;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign a_ok   = (32'(first_index) < 32'(STAR_DEPTH));
    assign b_ok   = (32'(second_index) < 32'(STAR_DEPTH));
    assign addr_a = AW'(first_index);
    assign addr_b = AW'(second_index);
    assign wr_en  = accept && (op == OP_LOAD) && a_ok;

    // Weight RAM: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            weight_mem[addr_a] <= weight_value;
        end
        rd_a_reg <= weight_mem[addr_a];
        rd_b_reg <= weight_mem[addr_b];
    end

    // Multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = MUL_W'(weight_value);
                mul_b = MUL_W'(weight_value);
            end
            ST_PAIR_MUL:
            begin
                mul_a = MUL_W'(rd_a_reg);
                mul_b = MUL_W'(rd_b_reg);
            end
            ST_SSQ:
            begin
                mul_a = MUL_W'(sum_reg);
                mul_b = MUL_W'(sum_reg);
            end
            ST_NORM:
            begin
                mul_a = MUL_W'(de_reg);
                mul_b = MUL_W'(de_reg);
            end
            ST_DESQ:
            begin
                mul_a = MUL_W'(me_reg);
                mul_b = MUL_W'(me_reg);
            end
            ST_RSQ:
            begin
                mul_a = ratio_reg;
                mul_b = ratio_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_next = mul_a * mul_b;

    // Saturating sums and close-bin arithmetic
    assign sum_add  = {1'b0, sum_reg} + (SUM_W+1)'(weight_value);
    assign sq_add   = {1'b0, sq_reg} + (SQ_W+1)'(mul_reg[MUL_W-1:0]);
    assign pair_add = {1'b0, pair_reg} + (PAIR_W+1)'(mul_reg[MUL_W-1:0]);
    assign chi_add  = {1'b0, chi2_reg} + (CHI_W+1)'(div_rsp.quotient);
    assign dof_add  = {1'b0, dof_reg} + (DOF_W+1)'(1);
    assign s2       = mul_reg[2*SUM_W-1:0];
    assign s2_diff  = s2 - (2*SUM_W)'(sq_reg);
    assign q32      = sat32(div_rsp.quotient);
    assign ratio_diff = (corr_reg >= ONE_Q24) ? (corr_reg - ONE_Q24) : (ONE_Q24 - corr_reg);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && out_stall;
        sum_next         = sum_reg;
        sq_next          = sq_reg;
        pair_next        = pair_reg;
        chi2_next        = chi2_reg;
        dof_next         = dof_reg;
        dd_next          = dd_reg;
        de_next          = de_reg;
        me_next          = me_reg;
        norm_next        = norm_reg;
        e2_next          = e2_reg;
        mm_next          = mm_reg;
        corr_next        = corr_reg;
        ratio_next       = ratio_reg;
        status_next      = status_reg;
        counted_next     = counted_reg;
        mm_out_next      = mm_out_reg;
        corr_out_next    = corr_out_reg;
        counted_out_next = counted_out_reg;
        chi2_out_next    = chi2_out_reg;
        dof_out_next     = dof_out_reg;
        status_out_next  = status_out_reg;
        div_req.start    = 1'b0;
        div_req.num      = '0;
        div_req.den      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_LOAD:
                        begin
                            if (a_ok)
                            begin
                                sum_next   = sum_add[SUM_W] ? {SUM_W{1'b1}}
                                                            : sum_add[SUM_W-1:0];
                                state_next = ST_LOAD_ACC;
                            end
                        end
                        OP_PAIR:
                        begin
                            if (a_ok && b_ok)
                            begin
                                state_next = ST_PAIR_MUL;
                            end
                        end
                        OP_CLOSE:
                        begin
                            dd_next      = dd_value;
                            de_next      = dd_frac_error;
                            me_next      = mm_frac_error;
                            mm_next      = '0;
                            corr_next    = '0;
                            counted_next = 1'b0;
                            state_next   = ST_SSQ;
                        end
                        OP_POINT:
                        begin
                            sum_next  = '0;
                            sq_next   = '0;
                            pair_next = '0;
                        end
                        OP_CLEAR:
                        begin
                            chi2_next = '0;
                            dof_next  = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD_ACC:
            begin
                sq_next    = sq_add[SQ_W] ? {SQ_W{1'b1}} : sq_add[SQ_W-1:0];
                state_next = ST_IDLE;
            end
            ST_PAIR_MUL:
            begin
                state_next = ST_PAIR_ACC;
            end
            ST_PAIR_ACC:
            begin
                pair_next  = pair_add[PAIR_W] ? {PAIR_W{1'b1}} : pair_add[PAIR_W-1:0];
                state_next = ST_IDLE;
            end
            ST_SSQ:
            begin
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // (S*S - Q) / 2, zero when S*S does not exceed Q
                norm_next  = (s2 > (2*SUM_W)'(sq_reg)) ? s2_diff[2*SUM_W-1:1] : '0;
                state_next = ST_DESQ;
            end
            ST_DESQ:
            begin
                e2_next    = E_W'(mul_reg[MUL_W-1:0]);
                state_next = ST_MESQ;
            end
            ST_MESQ:
            begin
                e2_next = e2_reg + E_W'(mul_reg[MUL_W-1:0]);
                if (norm_reg == '0)
                begin
                    status_next = 1'b1;
                    state_next  = ST_OUT;
                end
                else
                begin
                    status_next   = 1'b0;
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'({pair_reg, {FRAC_SH{1'b0}}});
                    div_req.den   = norm_reg;
                    state_next    = ST_DIV_MM;
                end
            end
            ST_DIV_MM:
            begin
                if (div_rsp.done)
                begin
                    mm_next = q32;
                    if ((dd_reg != '0) && (q32 != '0))
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = NUM_W'({dd_reg, {FRAC_SH{1'b0}}});
                        div_req.den   = DEN_W'(q32);
                        state_next    = ST_DIV_CORR;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV_CORR:
            begin
                if (div_rsp.done)
                begin
                    corr_next  = q32;
                    state_next = ST_RATIO_GO;
                end
            end
            ST_RATIO_GO:
            begin
                // sigma2 is nonzero only with nonzero corr and error sum
                if ((corr_reg != '0) && (e2_reg != '0))
                begin
                    div_req.start = 1'b1;
                    div_req.num   = NUM_W'({ratio_diff, {FRAC_SH{1'b0}}});
                    div_req.den   = DEN_W'(corr_reg);
                    state_next    = ST_DIV_RATIO;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV_RATIO:
            begin
                if (div_rsp.done)
                begin
                    ratio_next = q32;
                    state_next = ST_RSQ;
                end
            end
            ST_RSQ:
            begin
                state_next = ST_TERM_GO;
            end
            ST_TERM_GO:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(mul_reg);
                div_req.den   = DEN_W'({e2_reg, {TERM_SH{1'b0}}});
                state_next    = ST_DIV_TERM;
            end
            ST_DIV_TERM:
            begin
                if (div_rsp.done)
                begin
                    chi2_next    = chi_add[CHI_W] ? {CHI_W{1'b1}} : chi_add[CHI_W-1:0];
                    dof_next     = dof_add[DOF_W] ? {DOF_W{1'b1}} : dof_add[DOF_W-1:0];
                    counted_next = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hand the result to the output register once it is free
                if (out_free)
                begin
                    mm_out_next      = mm_reg;
                    corr_out_next    = corr_reg;
                    counted_out_next = counted_reg;
                    chi2_out_next    = chi2_reg;
                    dof_out_next     = dof_reg;
                    status_out_next  = status_reg;
                    out_valid_next   = 1'b1;
                    pair_next        = '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            pair_reg      <= '0;
            chi2_reg      <= '0;
            dof_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            pair_reg      <= pair_next;
            chi2_reg      <= chi2_next;
            dof_reg       <= dof_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        mul_reg         <= mul_next;
        dd_reg          <= dd_next;
        de_reg          <= de_next;
        me_reg          <= me_next;
        norm_reg        <= norm_next;
        e2_reg          <= e2_next;
        mm_reg          <= mm_next;
        corr_reg        <= corr_next;
        ratio_reg       <= ratio_next;
        status_reg      <= status_next;
        counted_reg     <= counted_next;
        mm_out_reg      <= mm_out_next;
        corr_out_reg    <= corr_out_next;
        counted_out_reg <= counted_out_next;
        chi2_out_reg    <= chi2_out_next;
        dof_out_reg     <= dof_out_next;
        status_out_reg  <= status_out_next;
    end

    // Shared divider
    wpcc_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid   = out_valid_reg;
    assign mm_value    = mm_out_reg;
    assign corr_value  = corr_out_reg;
    assign bin_counted = counted_out_reg;
    assign chi2_total  = chi2_out_reg;
    assign dof_count   = dof_out_reg;
    assign status      = status_out_reg;

endmodule

FILE: rtl/wpcc_checker.sv
// Port-level checker for the chi2 unit, bound to the top level.
module wpcc_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [wpcc_pkg::OUT_W-1:0]  mm_value,
    input logic [wpcc_pkg::OUT_W-1:0]  corr_value,
    input logic                        bin_counted,
    input logic [wpcc_pkg::CHI_W-1:0]  chi2_total,
    input logic [wpcc_pkg::DOF_W-1:0]  dof_count,
    input logic                        status
);
    // A stalled request stays offered
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("request dropped while stalled");

    // A held result keeps its MM, corr, chi2 total and dof count
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mm_value) && $stable(corr_value)
            && $stable(chi2_total) && $stable(dof_count))
        else $error("result changed while stalled");

    // Zero normalization leaves MM, corr and the count at zero
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> (mm_value == '0) && (corr_value == '0) && !bin_counted)
        else $error("zero normalization with nonzero result");

    // A counted bin has a nonzero corr, and corr needs a nonzero MM
    a_counted_corr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bin_counted |-> (corr_value != '0) && (mm_value != '0))
        else $error("counted bin with zero corr or MM");

    // A counted bin always has a nonzero dof count
    a_counted_dof: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bin_counted |-> (dof_count != '0))
        else $error("counted bin with zero dof count");

endmodule

bind weighted_pair_correlation_chi2_unit wpcc_checker u_wpcc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .mm_value    (mm_value),
    .corr_value  (corr_value),
    .bin_counted (bin_counted),
    .chi2_total  (chi2_total),
    .dof_count   (dof_count),
    .status      (status)
);
